FILE: sv/fwvm_pkg.sv
// fwvm_pkg: widths, register codes, reset values and the sideband word type
// shared by the mecanum velocity mixer top level and its scaling divider.
// No dependencies.
package fwvm_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DEADZONE     = 2'd0,
    REG_AXIS_GAIN    = 2'd1,
    REG_OUTPUT_LIMIT = 2'd2
  } cfg_reg_t;

  localparam int CFG_DATA_W = 10;

  localparam int AXIS_W  = 8;
  localparam int DZ_W    = 7;
  localparam int GAIN_W  = 10;
  localparam int LIMIT_W = 8;

  localparam logic [DZ_W-1:0]    DEADZONE_RST = 7'd20;
  localparam logic [GAIN_W-1:0]  GAIN_RST     = 10'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 8'd255;

  // magnitude * gain, at most 128 * 1023
  localparam int PROD_W = 17;
  // floor(p / 127) == (p * 132105) >> 24 for every p below 2^17
  localparam int                RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_127  = 18'd132105;
  localparam int                RECIP_SHIFT = 24;
  localparam int                SCALED_W    = PROD_W + RECIP_W;
  localparam int                VEL_W       = SCALED_W - RECIP_SHIFT;

  // wheel command: sum of three velocities
  localparam int CMD_W = 13;
  localparam int MAG_W = 12;

  // normalization divider: (mag * limit) / max, quotient below 256
  localparam int NUM_W  = MAG_W + LIMIT_W;
  localparam int QUOT_W = 8;
  localparam int WHEELS = 4;

  typedef struct packed {
    logic [WHEELS-1:0]             dir;
    logic [WHEELS-1:0][QUOT_W-1:0] mag_lo;
    logic                          scale;
  } fwvm_side_t;

endpackage

FILE: sv/four_wheel_velocity_mixer_unit.sv
// four_wheel_velocity_mixer_unit: mecanum inverse kinematics with deadzone,
// gain scaling and proportional normalization. Depends on fwvm_pkg, fwvm_scale_div.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+---------------------------
//   command  | forward_axis, strafe_axis, rotate_axis    | start & !busy
//   result   | wheelN_forward, wheelN_speed (N = 1..4)   | done, one cycle, no stall
//   config   | cfg_index, cfg_data                       | cfg_valid & cfg_ready
//
// One word accepted per cycle; each result passes through the 5 front stages
// (capture, gain multiply, divide by 127, mix, max/numerator), then the 8-stage
// normalization divider and the output register.
// Synchronous reset clears all valid bits and loads the register defaults;
// busy and !cfg_ready only during reset. Results are never held back.
module four_wheel_velocity_mixer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [fwvm_pkg::AXIS_W-1:0] forward_axis,
  input  logic signed [fwvm_pkg::AXIS_W-1:0] strafe_axis,
  input  logic signed [fwvm_pkg::AXIS_W-1:0] rotate_axis,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [fwvm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              done,
  output logic                              wheel1_forward,
  output logic [7:0]                        wheel1_speed,
  output logic                              wheel2_forward,
  output logic [7:0]                        wheel2_speed,
  output logic                              wheel3_forward,
  output logic [7:0]                        wheel3_speed,
  output logic                              wheel4_forward,
  output logic [7:0]                        wheel4_speed
);

  localparam int W = fwvm_pkg::WHEELS;

  // ---------------------------------------------------------------- config
  logic [fwvm_pkg::DZ_W-1:0]    deadzone;
  logic [fwvm_pkg::GAIN_W-1:0]  axis_gain;
  logic [fwvm_pkg::LIMIT_W-1:0] output_limit;
  logic                         accept;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone     <= fwvm_pkg::DEADZONE_RST;
      axis_gain    <= fwvm_pkg::GAIN_RST;
      output_limit <= fwvm_pkg::LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fwvm_pkg::cfg_reg_t'(cfg_index))
        fwvm_pkg::REG_DEADZONE:     deadzone     <= cfg_data[fwvm_pkg::DZ_W-1:0];
        fwvm_pkg::REG_AXIS_GAIN:    axis_gain    <= cfg_data[fwvm_pkg::GAIN_W-1:0];
        fwvm_pkg::REG_OUTPUT_LIMIT: output_limit <= cfg_data[fwvm_pkg::LIMIT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic                             s1_valid;
  logic [2:0][fwvm_pkg::AXIS_W-1:0] s1_axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_axis[0] <= forward_axis;
      s1_axis[1] <= strafe_axis;
      s1_axis[2] <= rotate_axis;
    end
  end

  // ---------------------------------------------------------------- stage 2: deadzone, gain
  // -128 gives magnitude 128 (0x80), which fits the unsigned byte
  logic [2:0][fwvm_pkg::AXIS_W-1:0] s1_mag;
  logic [2:0][fwvm_pkg::AXIS_W-1:0] s1_gated;
  logic [2:0][fwvm_pkg::PROD_W-1:0] s1_prod;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_mag[i]   = s1_axis[i][fwvm_pkg::AXIS_W-1] ? (~s1_axis[i] + 8'd1) : s1_axis[i];
      s1_gated[i] = (s1_mag[i] < {1'b0, deadzone}) ? '0 : s1_mag[i];
      s1_prod[i]  = {{(fwvm_pkg::PROD_W-fwvm_pkg::AXIS_W){1'b0}}, s1_gated[i]}
                  * {{(fwvm_pkg::PROD_W-fwvm_pkg::GAIN_W){1'b0}}, axis_gain};
    end
  end

  logic                             s2_valid;
  logic [2:0][fwvm_pkg::PROD_W-1:0] s2_prod;
  logic [2:0]                       s2_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_prod <= s1_prod;
    for (int i = 0; i < 3; i++) begin
      s2_neg[i] <= s1_axis[i][fwvm_pkg::AXIS_W-1];
    end
  end

  // ---------------------------------------------------------------- stage 3: divide by 127
  logic [2:0][fwvm_pkg::SCALED_W-1:0] s2_scaled;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_scaled[i] = {{fwvm_pkg::RECIP_W{1'b0}}, s2_prod[i]}
                   * {{fwvm_pkg::PROD_W{1'b0}}, fwvm_pkg::RECIP_127};
    end
  end

  logic                            s3_valid;
  logic [2:0][fwvm_pkg::VEL_W-1:0] s3_vel;
  logic [2:0]                      s3_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s3_vel[i] <= s2_scaled[i][fwvm_pkg::SCALED_W-1:fwvm_pkg::RECIP_SHIFT];
    end
    s3_neg <= s2_neg;
  end

  // ---------------------------------------------------------------- stage 4: wheel mix
  logic signed [fwvm_pkg::CMD_W-1:0] sv  [3];
  logic signed [fwvm_pkg::CMD_W-1:0] cmd [W];
  logic signed [fwvm_pkg::CMD_W-1:0] neg_cmd [W];
  logic [W-1:0]                      s3_dir;
  logic [W-1:0][fwvm_pkg::MAG_W-1:0] s3_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = $signed({2'b00, s3_vel[i]});
      if (s3_neg[i]) begin
        sv[i] = -$signed({2'b00, s3_vel[i]});
      end
    end
    cmd[0] =  sv[0] + sv[1] + sv[2];
    cmd[1] =  sv[0] - sv[1] - sv[2];
    cmd[2] = -sv[0] - sv[1] + sv[2];
    cmd[3] = -sv[0] + sv[1] - sv[2];
    for (int k = 0; k < W; k++) begin
      neg_cmd[k] = -cmd[k];
      s3_dir[k]  = !cmd[k][fwvm_pkg::CMD_W-1] && (cmd[k] != '0);
      s3_mag[k]  = cmd[k][fwvm_pkg::CMD_W-1] ? neg_cmd[k][fwvm_pkg::MAG_W-1:0]
                                             : cmd[k][fwvm_pkg::MAG_W-1:0];
    end
  end

  logic                              s4_valid;
  logic [W-1:0]                      s4_dir;
  logic [W-1:0][fwvm_pkg::MAG_W-1:0] s4_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_dir <= s3_dir;
    s4_mag <= s3_mag;
  end

  // ---------------------------------------------------------------- stage 5: max, numerators
  // scaling happens only when max > limit; then every mag <= max keeps the
  // quotient below 256, so eight divider stages are enough
  logic [fwvm_pkg::MAG_W-1:0]        max01;
  logic [fwvm_pkg::MAG_W-1:0]        max23;
  logic [fwvm_pkg::MAG_W-1:0]        s4_max;
  logic [W-1:0][fwvm_pkg::NUM_W-1:0] s4_num;
  fwvm_pkg::fwvm_side_t              s4_side;

  always_comb begin
    max01  = (s4_mag[0] > s4_mag[1]) ? s4_mag[0] : s4_mag[1];
    max23  = (s4_mag[2] > s4_mag[3]) ? s4_mag[2] : s4_mag[3];
    s4_max = (max01 > max23) ? max01 : max23;
    s4_side.dir   = s4_dir;
    s4_side.scale = s4_max >
                    {{(fwvm_pkg::MAG_W-fwvm_pkg::LIMIT_W){1'b0}}, output_limit};
    for (int k = 0; k < W; k++) begin
      s4_num[k] = {{fwvm_pkg::LIMIT_W{1'b0}}, s4_mag[k]}
                * {{fwvm_pkg::MAG_W{1'b0}}, output_limit};
      s4_side.mag_lo[k] = s4_mag[k][fwvm_pkg::QUOT_W-1:0];
    end
  end

  logic                              s5_valid;
  logic [W-1:0][fwvm_pkg::NUM_W-1:0] s5_num;
  logic [fwvm_pkg::MAG_W-1:0]        s5_max;
  fwvm_pkg::fwvm_side_t              s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_num  <= s4_num;
    s5_max  <= s4_max;
    s5_side <= s4_side;
  end

  // ---------------------------------------------------------------- normalization divider
  logic                               dv_valid;
  logic [W-1:0][fwvm_pkg::QUOT_W-1:0] dv_quot;
  fwvm_pkg::fwvm_side_t               dv_side;

  fwvm_scale_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .in_num    (s5_num),
    .in_den    (s5_max),
    .in_side   (s5_side),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // ---------------------------------------------------------------- output register
  logic [W-1:0]                       res_dir;
  logic [W-1:0][fwvm_pkg::QUOT_W-1:0] res_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    res_dir   <= dv_side.dir;
    res_speed <= dv_side.scale ? dv_quot : dv_side.mag_lo;
  end

  assign wheel1_forward = res_dir[0];
  assign wheel1_speed   = res_speed[0];
  assign wheel2_forward = res_dir[1];
  assign wheel2_speed   = res_speed[1];
  assign wheel3_forward = res_dir[2];
  assign wheel3_speed   = res_speed[2];
  assign wheel4_forward = res_dir[3];
  assign wheel4_speed   = res_speed[3];

  // ---------------------------------------------------------------- checks
  // every accepted word is followed by its done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##14 done)
    else $error("result strobe missing for accepted word");

  // no strobe without a word in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(dv_valid))
    else $error("result strobe without divider output");

  // wheel1 + wheel2 = -(wheel3 + wheel4): the pairs cannot both be all-forward
  a_pair_dir: assert property (@(posedge clk) disable iff (rst)
    (done && wheel1_forward && wheel2_forward) |-> !(wheel3_forward && wheel4_forward))
    else $error("inconsistent wheel directions");

endmodule

FILE: sv/fwvm_scale_div.sv
// fwvm_scale_div: four-lane restoring divider, one quotient bit per stage,
// shared divisor, sideband word carried alongside. Depends on fwvm_pkg.
module fwvm_scale_div (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               in_valid,
  input  logic [fwvm_pkg::WHEELS-1:0][fwvm_pkg::NUM_W-1:0]   in_num,
  input  logic [fwvm_pkg::MAG_W-1:0]                         in_den,
  input  fwvm_pkg::fwvm_side_t                               in_side,
  output logic                                               out_valid,
  output logic [fwvm_pkg::WHEELS-1:0][fwvm_pkg::QUOT_W-1:0]  out_quot,
  output fwvm_pkg::fwvm_side_t                               out_side
);

  localparam int STAGES = fwvm_pkg::QUOT_W;

  logic                                             valid [0:STAGES];
  logic [fwvm_pkg::WHEELS-1:0][fwvm_pkg::NUM_W-1:0]  rem  [0:STAGES];
  logic [fwvm_pkg::WHEELS-1:0][fwvm_pkg::QUOT_W-1:0] quot [0:STAGES];
  logic [fwvm_pkg::MAG_W-1:0]                       den  [0:STAGES];
  fwvm_pkg::fwvm_side_t                             side [0:STAGES];

  assign valid[0] = in_valid;
  assign rem[0]   = in_num;
  assign quot[0]  = '0;
  assign den[0]   = in_den;
  assign side[0]  = in_side;

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    // stage j settles quotient bit STAGES-1-j
    logic [fwvm_pkg::NUM_W-1:0] dsh;
    assign dsh = fwvm_pkg::NUM_W'(den[j]) << (STAGES - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j+1] <= 1'b0;
      end else begin
        valid[j+1] <= valid[j];
      end
      den[j+1]  <= den[j];
      side[j+1] <= side[j];
      for (int l = 0; l < fwvm_pkg::WHEELS; l++) begin
        if (rem[j][l] >= dsh) begin
          rem[j+1][l]  <= rem[j][l] - dsh;
          quot[j+1][l] <= {quot[j][l][fwvm_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          rem[j+1][l]  <= rem[j][l];
          quot[j+1][l] <= {quot[j][l][fwvm_pkg::QUOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = valid[STAGES];
  assign out_quot  = quot[STAGES];
  assign out_side  = side[STAGES];

endmodule

FILE: tb/tb_four_wheel_velocity_mixer_unit.sv
// tb_four_wheel_velocity_mixer_unit: self-checking bench for the mecanum wheel mixer;
// drives joystick words and register writes, predicts each wheel set in-bench.
// Depends on fwvm_pkg and four_wheel_velocity_mixer_unit.
module tb_four_wheel_velocity_mixer_unit;
  import fwvm_pkg::*;

  // one wheel set: direction bits and truncated magnitudes, index 0 = wheel 1
  typedef struct packed {
    logic [3:0]      fwd;
    logic [3:0][7:0] spd;
  } wheel_set_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic signed [7:0]      forward_axis;
  logic signed [7:0]      strafe_axis;
  logic signed [7:0]      rotate_axis;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   done;
  logic                   wheel1_forward, wheel2_forward, wheel3_forward, wheel4_forward;
  logic [7:0]             wheel1_speed, wheel2_speed, wheel3_speed, wheel4_speed;

  // bench copy of the register file, updated when a write is accepted
  logic [DZ_W-1:0]    dz_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [LIMIT_W-1:0] limit_q;

  // wheel sets still owed by the block, oldest first
  wheel_set_t pending_wheels[$];

  int mismatches;
  int commands_sent;
  int results_checked;
  int reg_writes;
  int settings_used;

  four_wheel_velocity_mixer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .forward_axis   (forward_axis),
    .strafe_axis    (strafe_axis),
    .rotate_axis    (rotate_axis),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .wheel1_forward (wheel1_forward),
    .wheel1_speed   (wheel1_speed),
    .wheel2_forward (wheel2_forward),
    .wheel2_speed   (wheel2_speed),
    .wheel3_forward (wheel3_forward),
    .wheel3_speed   (wheel3_speed),
    .wheel4_forward (wheel4_forward),
    .wheel4_speed   (wheel4_speed)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // deadzone, then gain/127 with truncation toward zero; -128 is magnitude 128
  function automatic int scale_axis(logic signed [7:0] ax);
    int m;
    m = (ax < 0) ? -int'(ax) : int'(ax);
    if (m < int'(dz_q)) return 0;
    m = (m * int'(gain_q)) / 127;
    return (ax < 0) ? -m : m;
  endfunction

  // mecanum mix plus proportional normalization against the output limit
  function automatic wheel_set_t mix_wheels(logic signed [7:0] fwd_ax, str_ax, rot_ax);
    int         vx, vy, om, peak;
    int         cmd[4];
    int         mag[4];
    wheel_set_t ws;
    vx = scale_axis(fwd_ax);
    vy = scale_axis(str_ax);
    om = scale_axis(rot_ax);
    cmd[0] =  vx + vy + om;
    cmd[1] =  vx - vy - om;
    cmd[2] = -vx - vy + om;
    cmd[3] = -vx + vy - om;
    peak = 0;
    for (int k = 0; k < 4; k++) begin
      mag[k] = (cmd[k] < 0) ? -cmd[k] : cmd[k];
      if (mag[k] > peak) peak = mag[k];
    end
    // peak equal to the limit is left alone; a zero limit zeroes any nonzero set
    for (int k = 0; k < 4; k++) begin
      if (peak > int'(limit_q)) mag[k] = (mag[k] * int'(limit_q)) / peak;
      // direction follows the raw command even if its magnitude truncates to 0
      ws.fwd[k] = (cmd[k] > 0);
      ws.spd[k] = 8'(mag[k]);
    end
    return ws;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: done is a one-cycle strobe, sampled at the closing edge
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    wheel_set_t got;
    wheel_set_t want;
    if (!rst && done) begin
      got.fwd = {wheel4_forward, wheel3_forward, wheel2_forward, wheel1_forward};
      got.spd = {wheel4_speed, wheel3_speed, wheel2_speed, wheel1_speed};
      if (pending_wheels.size() == 0) begin
        note_mismatch("result word with no command outstanding");
      end else begin
        want = pending_wheels.pop_front();
        results_checked++;
        for (int w = 0; w < 4; w++) begin
          if (got.fwd[w] !== want.fwd[w])
            note_mismatch($sformatf("wheel%0d_forward exp %0b got %0b",
                                    w + 1, want.fwd[w], got.fwd[w]));
          if (got.spd[w] !== want.spd[w])
            note_mismatch($sformatf("wheel%0d_speed exp %0d got %0d",
                                    w + 1, want.spd[w], got.spd[w]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // Present one command word; start stays high afterwards so back-to-back
  // words need no extra edge. Expectation is queued on the accepting edge.
  task automatic drive_command(logic signed [7:0] f, s, r);
    @(negedge clk);
    start        <= 1'b1;
    forward_axis <= f;
    strafe_axis  <= s;
    rotate_axis  <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_wheels.push_back(mix_wheels(f, s, r));
    commands_sent++;
  endtask

  // drop start for a gap set by n; n = 0 leaves none
  task automatic hold_off(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // mostly back-to-back, some short gaps, an occasional long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // stop sending and let every owed wheel set come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DEADZONE:     dz_q    = DZ_W'(value);
      REG_AXIS_GAIN:    gain_q  = GAIN_W'(value);
      REG_OUTPUT_LIMIT: limit_q = LIMIT_W'(value);
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers only change with the pipe empty
  task automatic write_config(int dz, int gain, int lim);
    wait_drained();
    write_register(REG_DEADZONE, dz);
    write_register(REG_AXIS_GAIN, gain);
    write_register(REG_OUTPUT_LIMIT, lim);
    settings_used++;
  endtask

  // axis mix: full-range bytes, values around the deadzone edge, extremes, small values
  function automatic logic signed [7:0] rand_axis();
    int r;
    int m;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(0, 255));
    if (r < 6) begin
      m = int'(dz_q) + $urandom_range(0, 2) - 1;
      if (m < 0) m = 0;
      if ($urandom_range(0, 1)) return 8'(-m);
      return 8'((m > 127) ? 127 : m);
    end
    if (r < 8) begin
      case ($urandom_range(0, 5))
        0: return -8'sd128;
        1: return -8'sd127;
        2: return 8'sd127;
        3: return 8'sd1;
        4: return -8'sd1;
        default: return 8'sd0;
      endcase
    end
    return 8'($urandom_range(0, 60) - 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset register values: axis extremes, deadzone edge, alternating and all-ones bit patterns
  task automatic test_default_extremes();
    drive_command(8'sd0, 8'sd0, 8'sd0);
    drive_command(8'sd127, 8'sd0, 8'sd0);
    drive_command(-8'sd128, 8'sd0, 8'sd0);
    drive_command(8'sd0, 8'sd127, 8'sd0);
    drive_command(8'sd0, -8'sd128, 8'sd0);
    drive_command(8'sd0, 8'sd0, 8'sd127);
    hold_off(3);
    drive_command(8'sd0, 8'sd0, -8'sd128);
    drive_command(8'sd19, -8'sd19, 8'sd19);    // just inside the deadzone
    drive_command(8'sd20, -8'sd20, 8'sd20);    // right at it
    drive_command(8'sd127, 8'sd127, 8'sd127);
    drive_command(-8'sd128, -8'sd128, -8'sd128);
    drive_command(8'sd85, -8'sd86, -8'sd1);    // 0x55, 0xAA, 0xFF
  endtask

  task automatic test_special_cases();
    // zero gain kills every velocity
    write_config(0, 0, 255);
    drive_command(8'sd127, -8'sd128, 8'sd55);
    // zero limit: nonzero set goes to all-zero speeds, zero set stays zero
    write_config(0, 127, 0);
    drive_command(8'sd50, -8'sd30, 8'sd10);
    drive_command(8'sd0, 8'sd0, 8'sd0);
    // limit 1: smaller wheels truncate to 0 but keep their direction
    write_config(0, 127, 1);
    drive_command(8'sd100, 8'sd1, 8'sd0);
    // unity gain: peak exactly at the limit vs one over it
    write_config(0, 127, 255);
    drive_command(8'sd127, 8'sd127, 8'sd1);
    drive_command(8'sd127, 8'sd127, 8'sd2);
    drive_command(-8'sd128, -8'sd128, -8'sd128);
    // widest deadzone with full gain: only the ends survive
    write_config(127, 1023, 255);
    drive_command(8'sd126, -8'sd127, -8'sd128);
  endtask

  task automatic test_random_mix();
    int dz, gain, lim;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_config(DEADZONE_RST, GAIN_RST, LIMIT_RST);
        1: write_config(0, 1023, 255);
        2: write_config(127, 1023, 1);
        3: write_config(0, 1, 255);
        default: begin
          dz   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 127);
          gain = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1023);
          lim  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
          write_config(dz, gain, lim);
        end
      endcase
      for (int i = 0; i < 166; i++) begin
        drive_command(rand_axis(), rand_axis(), rand_axis());
        // a burst with no gaps at the start of every setting
        if (i >= 20) hold_off(pick_gap());
        // sender waits out the whole pipe once mid-setting
        if (i == 83) wait_drained();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    forward_axis = '0;
    strafe_axis  = '0;
    rotate_axis  = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DEADZONE;
    cfg_data     = '0;
    dz_q         = DEADZONE_RST;
    gain_q       = GAIN_RST;
    limit_q      = LIMIT_RST;
    mismatches      = 0;
    commands_sent   = 0;
    results_checked = 0;
    reg_writes      = 0;
    settings_used   = 1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_extremes();
    test_special_cases();
    test_random_mix();

    wait_drained();
    repeat (20) @(posedge clk);   // pipe is 14 deep; catch any stray strobe

    $display("covered %0d command words over %0d register settings (%0d writes)",
             commands_sent, settings_used, reg_writes);
    $display("%0d wheel sets checked, %0d field mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending_wheels.size() == 0) begin
      $display("four_wheel_velocity_mixer_unit: match");
    end else begin
      $display("four_wheel_velocity_mixer_unit: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("timeout with %0d wheel sets outstanding", pending_wheels.size());
    $display("four_wheel_velocity_mixer_unit: mismatch");
    $finish;
  end

endmodule

FILE: four_wheel_velocity_mixer_unit.f
sv/fwvm_pkg.sv
sv/fwvm_scale_div.sv
sv/four_wheel_velocity_mixer_unit.sv
tb/tb_four_wheel_velocity_mixer_unit.sv
